@@ src/mptd_pkg.sv @@
package mptd_pkg;

	localparam int MAX_PENDING = 16;
	localparam int DELAY_BITS  = 20;
	localparam int IDX_W       = $clog2(MAX_PENDING);
	localparam int CNT_W       = $clog2(MAX_PENDING + 1);
	localparam int FIELD_W     = 5;
	localparam int CFG_W       = 20;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic accept;
		logic step;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic work_zero;
		logic last;
	} dp_status_t;

endpackage

@@ src/mptd_if.sv @@
interface mptd_in_if;
	logic valid;
	logic ready;
	logic trigger_in;

	modport source (output valid, output trigger_in, input ready);
	modport sink   (input valid, input trigger_in, output ready);
endinterface

interface mptd_out_if
	import mptd_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] fire_count;
	logic               dropped;
	logic [FIELD_W-1:0] pending_now;

	modport source (output valid, output fire_count, output dropped, output pending_now,
		input ready);
	modport sink   (input valid, input fire_count, input dropped, input pending_now,
		output ready);
endinterface

interface mptd_cfg_if
	import mptd_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] delay_frames;

	modport source (output valid, output delay_frames, input ready);
	modport sink   (input valid, input delay_frames, output ready);
endinterface

@@ src/mptd_ctrl.sv @@
module mptd_ctrl
	import mptd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		out_valid_d = out_valid_q && !out_ready;
		cmd         = '0;
		in_ready    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.work_zero) begin
					state_d = ST_FINISH;
				end else begin
					cmd.step = 1'b1;
					if (status.last)
						state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// hold the result until the output register frees up
				if (!out_valid_q || out_ready) begin
					cmd.finish  = 1'b1;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

@@ src/mptd_dp.sv @@
module mptd_dp
	import mptd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CFG_W-1:0]   cfg_delay,
	input  logic               trigger_in,
	input  dp_cmd_t            cmd,
	output dp_status_t         status,
	output logic [FIELD_W-1:0] fire_count,
	output logic               dropped,
	output logic [FIELD_W-1:0] pending_now
);

	logic [DELAY_BITS-1:0] slot_q [MAX_PENDING];
	logic [DELAY_BITS-1:0] delay_q;
	logic [CNT_W-1:0]      used_q;
	logic [CNT_W-1:0]      work_q;
	logic [IDX_W-1:0]      rd_idx_q;
	logic [CNT_W-1:0]      kept_q;
	logic [CNT_W-1:0]      fired_q;
	logic                  drop_q;
	logic [FIELD_W-1:0]    fire_out_q;
	logic                  drop_out_q;
	logic [FIELD_W-1:0]    pend_out_q;

	logic                  has_room;
	logic [DELAY_BITS-1:0] cur;

	assign has_room = used_q < CNT_W'(MAX_PENDING);
	assign cur      = slot_q[rd_idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= '0;
			used_q  <= '0;
		end else begin
			if (cfg_we)
				delay_q <= DELAY_BITS'(cfg_delay);
			if (cmd.finish)
				used_q <= kept_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			// capture the trigger at the tail of the pending list
			if (trigger_in && has_room) begin
				slot_q[used_q[IDX_W-1:0]] <= delay_q;
				work_q <= used_q + CNT_W'(1);
			end else begin
				work_q <= used_q;
			end
			drop_q   <= trigger_in && !has_room;
			rd_idx_q <= '0;
			kept_q   <= '0;
			fired_q  <= '0;
		end
		if (cmd.step) begin
			// fire a zero slot, else count down and compact toward the head
			if (cur == '0) begin
				fired_q <= fired_q + CNT_W'(1);
			end else begin
				slot_q[kept_q[IDX_W-1:0]] <= cur - DELAY_BITS'(1);
				kept_q <= kept_q + CNT_W'(1);
			end
			rd_idx_q <= rd_idx_q + IDX_W'(1);
		end
		if (cmd.finish) begin
			fire_out_q <= FIELD_W'(fired_q);
			drop_out_q <= drop_q;
			pend_out_q <= FIELD_W'(kept_q);
		end
	end

	assign status.work_zero = (work_q == '0);
	assign status.last      = (CNT_W'(rd_idx_q) == (work_q - CNT_W'(1)));

	assign fire_count  = fire_out_q;
	assign dropped     = drop_out_q;
	assign pending_now = pend_out_q;

endmodule

@@ src/multi_pending_trigger_delay.sv @@
// Multi-pending trigger delay: one item is one audio frame carrying a trigger
// flag. A trigger takes a countdown slot loaded with delay_frames when fewer
// than 16 slots are pending, otherwise it is dropped and flagged. Each frame,
// slots at zero fire and leave, the rest count down by one and close ranks
// in order, so a trigger fires exactly delay_frames frames after it arrives
// (in its own frame for a delay of zero). Each item yields one result with
// fire_count, dropped and pending_now. An item is first captured, then the
// slot bank, holding the slots pending once the new trigger is captured, is
// walked one slot per cycle through a single read port, and then the result
// is posted; posting waits while the output register holds an untaken result.
// The result sits in an output register, so the next item is taken while it
// waits. delay_frames is written through cfg at any time the block is idle,
// and only affects triggers captured afterwards.
module multi_pending_trigger_delay
	import mptd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	mptd_in_if.sink    in_ch,
	mptd_out_if.source out_ch,
	mptd_cfg_if.sink   cfg
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// the delay register takes a write every cycle
	assign cfg.ready = 1'b1;

	mptd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	mptd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg.valid && cfg.ready),
		.cfg_delay   (cfg.delay_frames),
		.trigger_in  (in_ch.trigger_in),
		.cmd         (cmd),
		.status      (status),
		.fire_count  (out_ch.fire_count),
		.dropped     (out_ch.dropped),
		.pending_now (out_ch.pending_now)
	);

	// never more slots in play than the bank holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.pending_now <= FIELD_W'(MAX_PENDING)))
		else $error("pending count exceeds slot bank");

	// fired plus surviving slots cannot exceed the bank
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |->
		((6'(out_ch.fire_count) + 6'(out_ch.pending_now)) <= 6'(MAX_PENDING)))
		else $error("fired and pending slots exceed slot bank");

	// an accepted item blocks new items until its result is posted
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("item accepted during scan");

endmodule

@@ sim/tb_multi_pending_trigger_delay.sv @@
module tb_multi_pending_trigger_delay
	import mptd_pkg::*;
();

	// Stop the run after this many cycles in a row without any handshake.
	localparam int WATCHDOG_LIMIT = 2000;
	// Cycles to let pass after the last result before touching the register.
	localparam int SETTLE_CYCLES  = MAX_PENDING + 8;
	localparam int RANDOM_ITEMS   = 1300;

	typedef struct packed {
		logic [FIELD_W-1:0] fire_count;
		logic               dropped;
		logic [FIELD_W-1:0] pending_now;
	} frame_result_t;

	// Tracks the countdown bank and the queue of results owed by the block.
	class trigger_delay_scoreboard;
		logic [DELAY_BITS-1:0] delay;
		logic [DELAY_BITS-1:0] countdown [MAX_PENDING];
		int unsigned           used;
		frame_result_t         expected_q [$];
		int unsigned           errors;

		function new();
			delay  = '0;
			used   = 0;
			errors = 0;
		endfunction

		function void set_delay(logic [CFG_W-1:0] value);
			delay = value[DELAY_BITS-1:0];
		endfunction

		// Advance the bank by one frame and queue the result it must produce.
		function void note_frame(logic trig);
			frame_result_t         r;
			int unsigned           fired;
			int unsigned           kept;
			logic [DELAY_BITS-1:0] v;
			r.dropped = 1'b0;
			if (trig) begin
				if (used < MAX_PENDING) begin
					countdown[used] = delay;
					used++;
				end else begin
					r.dropped = 1'b1;
				end
			end
			fired = 0;
			kept  = 0;
			for (int i = 0; i < used; i++) begin
				v = countdown[i];
				if (v == '0) begin
					fired++;
				end else begin
					countdown[kept] = v - 1'b1;
					kept++;
				end
			end
			used          = kept;
			r.fire_count  = FIELD_W'(fired);
			r.pending_now = FIELD_W'(kept);
			expected_q.push_back(r);
		endfunction

		function void check_result(frame_result_t got);
			frame_result_t want;
			if (expected_q.size() == 0) begin
				if (errors < 10)
					$display({"result with nothing expected: ",
						"fire_count=%0d dropped=%0d pending_now=%0d"},
						got.fire_count, got.dropped, got.pending_now);
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (got != want) begin
					if (errors < 10)
						$display({"mismatch: expected fire_count=%0d dropped=%0d ",
							"pending_now=%0d, got %0d %0d %0d"},
							want.fire_count, want.dropped, want.pending_now,
							got.fire_count, got.dropped, got.pending_now);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	mptd_in_if  in_ch ();
	mptd_out_if out_ch ();
	mptd_cfg_if cfg_ch ();

	multi_pending_trigger_delay dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg_ch)
	);

	trigger_delay_scoreboard sb = new();

	// Upper bounds of the per-item idle draws; each phase picks 0 or 9.
	int unsigned gap_max;
	int unsigned stall_max;
	int unsigned items_sent;
	int unsigned idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one frame: idle a random number of cycles, then hold valid until the
	// block takes the item. Valid stays high on return so back-to-back items
	// never see a low-high pair of assignments in one step.
	task automatic send_frame(input logic trig);
		int unsigned gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.trigger_in <= trig;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_frame(trig);
		items_sent++;
	endtask

	// Drop valid, then wait for every owed result plus the block's tail.
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write delay_frames only once the block is idle.
	task automatic write_delay(input logic [CFG_W-1:0] value);
		settle();
		cfg_ch.valid        <= 1'b1;
		cfg_ch.delay_frames <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		sb.set_delay(value);
	endtask

	// Feed empty frames until no slot is pending.
	task automatic drain_slots();
		while (sb.used != 0) send_frame(1'b0);
	endtask

	// Capture 16 triggers on consecutive frames with descending delays so that
	// all of them fire in the same frame: fire_count reaches its top value.
	task automatic converge_burst();
		int unsigned base;
		base = $urandom_range(0, 5);
		drain_slots();
		for (int i = 0; i < MAX_PENDING; i++) begin
			write_delay(CFG_W'(base + MAX_PENDING - 1 - i));
			send_frame(1'b1);
		end
		drain_slots();
	endtask

	// Result side: stall a random number of cycles per item, then take one.
	initial begin : result_sink
		int unsigned   stall;
		frame_result_t got;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = $urandom_range(0, stall_max);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			got.fire_count  = out_ch.fire_count;
			got.dropped     = out_ch.dropped;
			got.pending_now = out_ch.pending_now;
			sb.check_result(got);
		end
	end

	// Watchdog: any handshake on any channel restarts the count.
	initial begin : watchdog
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int unsigned kind;
		int unsigned density;
		int unsigned count;
		logic [CFG_W-1:0] delay_pick;

		in_ch.valid         <= 1'b0;
		in_ch.trigger_in    <= 1'b0;
		out_ch.ready        <= 1'b0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.delay_frames <= '0;
		arst_n              <= 1'b0;
		gap_max    = 0;
		stall_max  = 0;
		items_sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero delay: a trigger fires in its own frame; an empty frame drops nothing.
		write_delay('0);
		send_frame(1'b1);
		send_frame(1'b1);
		send_frame(1'b0);

		// Short delay with interleaved empty frames.
		write_delay(CFG_W'(2));
		send_frame(1'b1);
		send_frame(1'b0);
		send_frame(1'b1);
		send_frame(1'b0);
		send_frame(1'b0);
		send_frame(1'b0);

		// Fill all slots, then keep triggering: the extra triggers are dropped
		// while pending slots keep counting. The delay change only hits new ones.
		write_delay(CFG_W'(20));
		for (int i = 0; i < MAX_PENDING + 2; i++) send_frame(1'b1);

		// Random phases, each with its own delay, trigger density and idling.
		while (items_sent < RANDOM_ITEMS) begin
			gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 9;
			stall_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
			kind      = $urandom_range(0, 5);
			density   = $urandom_range(5, 100);
			case (kind)
				0: delay_pick = '0;
				1: delay_pick = CFG_W'($urandom_range(1, 3));
				2: delay_pick = CFG_W'($urandom_range(0, 40));
				3: begin
					delay_pick = CFG_W'($urandom_range(10, 30));
					density    = 100;
				end
				4: delay_pick = CFG_W'($urandom_range(0, 8));
				default: delay_pick = CFG_W'($urandom_range(0, 200));
			endcase
			if (kind == 4) begin
				converge_burst();
			end else begin
				write_delay(delay_pick);
				count = $urandom_range(40, 120);
				for (int i = 0; i < count; i++)
					send_frame($urandom_range(0, 99) < density);
			end
		end

		// Huge delays last: these slots never fire within the run, so the bank
		// fills and later triggers are dropped while it is full.
		gap_max   = 9;
		stall_max = 9;
		write_delay(CFG_W'($urandom_range(1000, 1048574)));
		for (int i = 0; i < 10; i++) send_frame(1'($urandom_range(0, 1)));
		write_delay({CFG_W{1'b1}});
		for (int i = 0; i < MAX_PENDING + 10; i++) send_frame(1'b1);

		in_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/mptd_pkg.sv
src/mptd_if.sv
src/mptd_ctrl.sv
src/mptd_dp.sv
src/multi_pending_trigger_delay.sv
sim/tb_multi_pending_trigger_delay.sv
